>>> hdl/ksa_pkg.sv
// ksa_pkg: shared constants for the key slot allocator
// status codes, field widths and stream packing positions
// no dependencies
package ksa_pkg;

	localparam int NOTE_W = 7;
	localparam int TIME_W = 32;
	localparam int SECT_W = 8;
	localparam int KCNT_W = 4;
	localparam int SLOT_W = 3;
	localparam int STAT_W = 2;

	localparam logic [KCNT_W-1:0] KCNT_RESET = 4'd4;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_DROPPED   = 2'd1;
	localparam logic [STAT_W-1:0] ST_UNMATCHED = 2'd2;

	// input tdata: note, time, section, one pad bit
	localparam int IN_TDATA_W = 48;
	// output tdata: slot, note, time, section, pad to whole bytes
	localparam int OUT_TDATA_W = 56;
	// output tuser: press flag, status
	localparam int OUT_TUSER_W = 3;

endpackage

>>> hdl/ksa_ram.sv
// ksa_ram: generic simple dual-port ram, one write and one read port
// read data registered; no dependencies
module ksa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/key_slot_allocator.sv
// key_slot_allocator: assigns note press/release events to player key slots
// steps: note modulo key count by restoring division, one note bit per step,
// then per slot examined a ram read then a compare, then the output load
// a new event is taken only when idle; the slot scan and output back-pressure set this
// reset (arst_n low): all slots empty, key count 4, output empty
// uses ksa_pkg and ksa_ram
module key_slot_allocator #(
	parameter int MAX_KEYS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ksa_pkg::KCNT_W-1:0]        cfg_wdata,      // key_count
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [ksa_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // note_number, event_time, section
	input  logic [0:0]                        s_axis_tuser,   // press
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [ksa_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // slot_index, note_out, time_out, section_out
	output logic [ksa_pkg::OUT_TUSER_W-1:0]   m_axis_tuser    // press_out, status
);

	localparam int IDXW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int KCAP = (MAX_KEYS > 15) ? 15 : MAX_KEYS;
	localparam int NW   = ksa_pkg::NOTE_W;
	localparam int TW   = ksa_pkg::TIME_W;
	localparam int SW   = ksa_pkg::SECT_W;
	localparam int KW   = ksa_pkg::KCNT_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_RD,
		S_CMP,
		S_OUT
	} state_t;

	state_t                   state_q;
	logic [KW-1:0]            kcnt_q;
	logic [MAX_KEYS-1:0]      valid_q;
	logic [NW-1:0]            note_q;
	logic                     press_q;
	logic [TW-1:0]            time_q;
	logic [SW-1:0]            sect_q;
	logic [KW-1:0]            rem_q;
	logic [2:0]               bit_q;
	logic [IDXW-1:0]          cur_q;
	logic [KW-1:0]            cnt_q;
	logic [IDXW-1:0]          slot_q;
	logic [ksa_pkg::STAT_W-1:0] status_q;

	logic                     mvalid_q;
	logic [ksa_pkg::SLOT_W-1:0] out_slot_q;
	logic                     out_press_q;
	logic [NW-1:0]            out_note_q;
	logic [TW-1:0]            out_time_q;
	logic [SW-1:0]            out_sect_q;
	logic [ksa_pkg::STAT_W-1:0] out_status_q;

	logic [KW-1:0]            k_act;
	logic [KW:0]              trial;
	logic [KW-1:0]            rem_next;
	logic [NW-1:0]            rd_note;
	logic                     ram_we;
	logic                     hit;
	logic                     last_slot;
	logic                     wrap;
	logic                     out_load;

	// zero keys acts as one, counts above the table size saturate
	always_comb begin
		if (kcnt_q == '0) begin
			k_act = KW'(1);
		end else if (kcnt_q > KW'(KCAP)) begin
			k_act = KW'(KCAP);
		end else begin
			k_act = kcnt_q;
		end
	end

	// one restoring step of note modulo k
	always_comb begin
		trial = {rem_q, note_q[bit_q]};
		if (trial >= {1'b0, k_act}) begin
			rem_next = KW'(trial - {1'b0, k_act});
		end else begin
			rem_next = trial[KW-1:0];
		end
	end

	assign hit       = press_q ? !valid_q[cur_q] : (valid_q[cur_q] && (rd_note == note_q));
	assign last_slot = ((KW+1)'(cnt_q) + (KW+1)'(1)) == (KW+1)'(k_act);
	assign wrap      = (7'(cur_q) + 7'd1) == 7'(k_act);
	assign ram_we    = (state_q == S_CMP) && press_q && hit;
	assign out_load  = (state_q == S_OUT) && (!mvalid_q || m_axis_tready);

	ksa_ram #(
		.WIDTH(NW),
		.DEPTH(MAX_KEYS)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cur_q),
		.wdata(note_q),
		.re   (state_q == S_RD),
		.raddr(cur_q),
		.rdata(rd_note)
	);

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = mvalid_q;
	assign m_axis_tdata  = {6'd0, out_sect_q, out_time_q, out_note_q, out_slot_q};
	assign m_axis_tuser  = {out_status_q, out_press_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			kcnt_q       <= ksa_pkg::KCNT_RESET;
			valid_q      <= '0;
			note_q       <= '0;
			press_q      <= 1'b0;
			time_q       <= '0;
			sect_q       <= '0;
			rem_q        <= '0;
			bit_q        <= '0;
			cur_q        <= '0;
			cnt_q        <= '0;
			slot_q       <= '0;
			status_q     <= ksa_pkg::ST_OK;
			mvalid_q     <= 1'b0;
			out_slot_q   <= '0;
			out_press_q  <= 1'b0;
			out_note_q   <= '0;
			out_time_q   <= '0;
			out_sect_q   <= '0;
			out_status_q <= ksa_pkg::ST_OK;
		end else begin
			if (cfg_we) begin
				kcnt_q <= cfg_wdata;
			end
			if (out_load) begin
				mvalid_q <= 1'b1;
			end else if (mvalid_q && m_axis_tready) begin
				mvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						note_q  <= s_axis_tdata[NW-1:0];
						time_q  <= s_axis_tdata[NW+TW-1:NW];
						sect_q  <= s_axis_tdata[NW+TW+SW-1:NW+TW];
						press_q <= s_axis_tuser[0];
						rem_q   <= '0;
						bit_q   <= 3'(NW - 1);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= rem_next;
					bit_q <= bit_q - 3'd1;
					if (bit_q == '0) begin
						cur_q    <= IDXW'(rem_next);
						cnt_q    <= '0;
						slot_q   <= '0;
						status_q <= press_q ? ksa_pkg::ST_DROPPED : ksa_pkg::ST_UNMATCHED;
						state_q  <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (hit) begin
						valid_q[cur_q] <= press_q;
						slot_q         <= cur_q;
						status_q       <= ksa_pkg::ST_OK;
						state_q        <= S_OUT;
					end else if (last_slot) begin
						state_q <= S_OUT;
					end else begin
						cur_q   <= wrap ? '0 : cur_q + IDXW'(1);
						cnt_q   <= cnt_q + KW'(1);
						state_q <= S_RD;
					end
				end
				S_OUT: begin
					// wait for the output register to drain
					if (out_load) begin
						out_slot_q   <= ksa_pkg::SLOT_W'(slot_q);
						out_press_q  <= press_q;
						out_note_q   <= note_q;
						out_time_q   <= time_q;
						out_sect_q   <= sect_q;
						out_status_q <= status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
